>>> design/srtf_pkg.sv
// Shared codes, state encoding and default sizes for the SRTF tick scheduler.
`timescale 1ns / 1ps
package srtf_pkg;

    localparam int DEF_MAX_JOBS  = 16;
    localparam int DEF_TIME_BITS = 16;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_LOADED  = 3'd0,
        ST_REJECT  = 3'd1,
        ST_RAN     = 3'd2,
        ST_IDLE    = 3'd3,
        ST_CLEARED = 3'd4
    } t_status;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_WAIT = 6'b000100,
        S_RUN  = 6'b001000,
        S_TAT  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

endpackage

>>> design/srtf_job_mem.sv
// Job table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module srtf_job_mem #(
    parameter int DEPTH = srtf_pkg::DEF_MAX_JOBS,
    parameter int AW    = $clog2(srtf_pkg::DEF_MAX_JOBS),
    parameter int DW    = 3 * srtf_pkg::DEF_TIME_BITS
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    import srtf_pkg::*;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/srtf_pick.sv
// Running best-job tracker: folds in one table entry per beat.
`timescale 1ns / 1ps
module srtf_pick #(
    parameter int TIME_BITS = srtf_pkg::DEF_TIME_BITS,
    parameter int SLOT_W    = $clog2(srtf_pkg::DEF_MAX_JOBS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clr,
    input  logic                 i_vld,
    input  logic [SLOT_W-1:0]    i_idx,
    input  logic [TIME_BITS-1:0] i_arr,
    input  logic [TIME_BITS-1:0] i_bur,
    input  logic [TIME_BITS-1:0] i_rem,
    input  logic [TIME_BITS-1:0] i_now,
    output logic                 o_found,
    output logic [SLOT_W-1:0]    o_slot,
    output logic [TIME_BITS-1:0] o_arr,
    output logic [TIME_BITS-1:0] o_bur,
    output logic [TIME_BITS-1:0] o_rem
);
    import srtf_pkg::*;

    logic                 r_found;
    logic [SLOT_W-1:0]    r_slot;
    logic [TIME_BITS-1:0] r_arr;
    logic [TIME_BITS-1:0] r_bur;
    logic [TIME_BITS-1:0] r_rem;
    logic                 eligible;
    logic                 better;
    logic                 take;

    // arrived and unfinished; strict compares keep the lower slot on a full tie
    assign eligible = (i_arr <= i_now) && (i_rem != '0);
    assign better   = !r_found || (i_rem < r_rem) || ((i_rem == r_rem) && (i_arr < r_arr));
    assign take     = i_vld && eligible && better;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_clr) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_slot <= i_idx;
            r_arr  <= i_arr;
            r_bur  <= i_bur;
            r_rem  <= i_rem;
        end
    end

    assign o_found = r_found;
    assign o_slot  = r_slot;
    assign o_arr   = r_arr;
    assign o_bur   = r_bur;
    assign o_rem   = r_rem;

endmodule

>>> design/srtf_tick_scheduler_top.sv
// Top level of the shortest-remaining-time-first tick scheduler.
`timescale 1ns / 1ps
// Usage
//   Command channel: drive i_operation, i_arrival_time and i_burst_length with
//   start high; the beat is taken at the rising edge where busy is low.
//   Every command yields exactly one result beat, shown for one cycle with
//   o_strobe high. The receiver cannot stall; results are never held back.
// Latency / throughput
//   Load, clear and unknown operations: result in the cycle after accept,
//   busy stays low, so one such command can be issued every cycle.
//   Tick: the job table memory is scanned one slot per cycle for the job with
//   least remaining time, then the chosen entry is written back and the
//   turnaround and waiting figures are formed in two further steps.
//   A tick keeps busy high through the scan, S_WAIT, S_RUN, S_TAT and S_DONE
//   (an empty table skips the scan and S_WAIT); its result is registered in
//   S_DONE. The single read port of the job memory sets the scan length.
// Reset
//   i_rst_n is synchronous, active low: job count and clock go to zero and
//   the sequencer returns to idle. The table memory is not cleared; only
//   slots below the job count are ever read. A clear command does the same.
// Times saturate at all ones; the clock stops there but jobs still run.
module srtf_tick_scheduler_top #(
    parameter int MAX_JOBS  = srtf_pkg::DEF_MAX_JOBS,
    parameter int TIME_BITS = srtf_pkg::DEF_TIME_BITS,
    parameter int SLOT_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_operation,
    input  logic [TIME_BITS-1:0]    i_arrival_time,
    input  logic [TIME_BITS-1:0]    i_burst_length,
    output logic                    o_strobe,
    output srtf_pkg::t_status       o_status,
    output logic [SLOT_W-1:0]       o_slot,
    output logic [TIME_BITS-1:0]    o_current_time,
    output logic                    o_job_finished,
    output logic [TIME_BITS-1:0]    o_completion_time,
    output logic [TIME_BITS-1:0]    o_turnaround_time,
    output logic [TIME_BITS-1:0]    o_waiting_time
);
    import srtf_pkg::*;

    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int DW    = 3 * TIME_BITS;
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    // control state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [TIME_BITS-1:0] r_clock, n_clock;
    logic [SLOT_W-1:0]  r_rd_idx, n_rd_idx;
    logic               r_cmp_vld, n_cmp_vld;
    logic [SLOT_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic [TIME_BITS-1:0] r_tat, n_tat;

    // result beat
    logic               r_strobe, n_strobe;
    t_status            r_status, n_status;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [TIME_BITS-1:0] r_time, n_time;
    logic               r_fin, n_fin;
    logic [TIME_BITS-1:0] r_ct, n_ct;
    logic [TIME_BITS-1:0] r_tat_o, n_tat_o;
    logic [TIME_BITS-1:0] r_wt, n_wt;

    // memory and picker hookup
    logic               mem_we;
    logic [SLOT_W-1:0]  mem_waddr;
    logic [DW-1:0]      mem_wdata;
    logic [DW-1:0]      mem_rdata;
    logic               pick_clr;
    logic               best_found;
    logic [SLOT_W-1:0]  best_slot;
    logic [TIME_BITS-1:0] best_arr;
    logic [TIME_BITS-1:0] best_bur;
    logic [TIME_BITS-1:0] best_rem;
    logic [TIME_BITS-1:0] clock_inc;
    logic               accept;

    assign accept    = start && !busy;
    assign clock_inc = (r_clock == TMAX) ? r_clock : r_clock + 1'b1;

    // Entry layout: {arrival, burst, remaining}. Writes happen at load accept
    // and in S_RUN; reads only in S_SCAN, never in the same cycle as a write,
    // so no forwarding path is needed.
    srtf_job_mem #(
        .DEPTH (MAX_JOBS),
        .AW    (SLOT_W),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (mem_rdata)
    );

    srtf_pick #(
        .TIME_BITS (TIME_BITS),
        .SLOT_W    (SLOT_W)
    ) u_pick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (pick_clr),
        .i_vld   (r_cmp_vld),
        .i_idx   (r_cmp_idx),
        .i_arr   (mem_rdata[DW-1 -: TIME_BITS]),
        .i_bur   (mem_rdata[2*TIME_BITS-1 -: TIME_BITS]),
        .i_rem   (mem_rdata[TIME_BITS-1:0]),
        .i_now   (r_clock),
        .o_found (best_found),
        .o_slot  (best_slot),
        .o_arr   (best_arr),
        .o_bur   (best_bur),
        .o_rem   (best_rem)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_clock   = r_clock;
        n_rd_idx  = r_rd_idx;
        n_cmp_vld = 1'b0;
        n_cmp_idx = r_rd_idx;
        n_tat     = r_tat;
        n_strobe  = 1'b0;
        n_status  = r_status;
        n_slot    = r_slot;
        n_time    = r_time;
        n_fin     = r_fin;
        n_ct      = r_ct;
        n_tat_o   = r_tat_o;
        n_wt      = r_wt;
        mem_we    = 1'b0;
        mem_waddr = r_count[SLOT_W-1:0];
        mem_wdata = {i_arrival_time, i_burst_length, i_burst_length};
        pick_clr  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_strobe = 1'b1;
                    n_status = ST_REJECT;
                    n_slot   = '0;
                    n_time   = r_clock;
                    n_fin    = 1'b0;
                    n_ct     = '0;
                    n_tat_o  = '0;
                    n_wt     = '0;
                    case (i_operation)
                        OP_LOAD: begin
                            if (i_burst_length != '0 && r_count != CNT_W'(MAX_JOBS)) begin
                                mem_we   = 1'b1;
                                n_count  = r_count + 1'b1;
                                n_status = ST_LOADED;
                                n_slot   = r_count[SLOT_W-1:0];
                            end
                        end
                        OP_TICK: begin
                            n_strobe = 1'b0;
                            pick_clr = 1'b1;
                            n_rd_idx = '0;
                            n_state  = (r_count == '0) ? S_RUN : S_SCAN;
                        end
                        OP_CLEAR: begin
                            n_count  = '0;
                            n_clock  = '0;
                            n_time   = '0;
                            n_status = ST_CLEARED;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // read issued now, compared next cycle
                n_cmp_vld = 1'b1;
                n_rd_idx  = r_rd_idx + 1'b1;
                if (CNT_W'(r_rd_idx) == r_count - 1'b1) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_RUN;
            end
            S_RUN: begin
                if (best_found) begin
                    mem_we    = 1'b1;
                    mem_waddr = best_slot;
                    mem_wdata = {best_arr, best_bur, best_rem - 1'b1};
                end
                n_clock = clock_inc;
                n_state = S_TAT;
            end
            S_TAT: begin
                n_tat   = r_clock - best_arr;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_strobe = 1'b1;
                n_time   = r_clock;
                n_fin    = 1'b0;
                n_ct     = '0;
                n_tat_o  = '0;
                n_wt     = '0;
                if (best_found) begin
                    n_status = ST_RAN;
                    n_slot   = best_slot;
                    if (best_rem == TIME_BITS'(1)) begin
                        n_fin   = 1'b1;
                        n_ct    = r_clock;
                        n_tat_o = r_tat;
                        // saturated clock can leave turnaround below burst
                        n_wt    = (r_tat >= best_bur) ? r_tat - best_bur : '0;
                    end
                end else begin
                    n_status = ST_IDLE;
                    n_slot   = '0;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_clock   <= '0;
            r_cmp_vld <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_clock   <= n_clock;
            r_cmp_vld <= n_cmp_vld;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_tat     <= n_tat;
        r_status  <= n_status;
        r_slot    <= n_slot;
        r_time    <= n_time;
        r_fin     <= n_fin;
        r_ct      <= n_ct;
        r_tat_o   <= n_tat_o;
        r_wt      <= n_wt;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_strobe          = r_strobe;
    assign o_status          = r_status;
    assign o_slot            = r_slot;
    assign o_current_time    = r_time;
    assign o_job_finished    = r_fin;
    assign o_completion_time = r_ct;
    assign o_turnaround_time = r_tat_o;
    assign o_waiting_time    = r_wt;

    // a result beat never overlaps a tick still in the sequencer
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> r_state == S_IDLE)
        else $error("result beat while sequencer busy");

    // the job count never passes the table depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_JOBS))
        else $error("job count beyond table depth");

    // an accepted tick always occupies the sequencer in the next cycle
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_operation == OP_TICK) |=> busy)
        else $error("tick accepted but sequencer idle");

    // a finished job never waits longer than its turnaround
    a_wait_le_tat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_job_finished) |-> o_waiting_time <= o_turnaround_time)
        else $error("waiting time exceeds turnaround");

endmodule
